// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with reset disable
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication with reset disable
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/hrlp_pkg.sv =====
// Shared types, codes and the URI character table for the request-line parser.
// No dependencies.
package hrlp_pkg;
  localparam int POS_BITS = 13;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [2:0] RES_AGAIN = 3'd0;
  localparam logic [2:0] RES_DONE = 3'd1;
  localparam logic [2:0] RES_BAD_METHOD = 3'd2;
  localparam logic [2:0] RES_BAD_REQ = 3'd3;
  localparam logic [2:0] RES_BAD_VER = 3'd4;
  localparam logic [2:0] RES_BAD_09 = 3'd5;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_POST = 2'd2;

  localparam logic [255:0] PLAIN_CHARS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h7fffffff, 32'hffffffff, 32'h7fff37d6, 32'h00000000};

  // byte class decided by the front part
  typedef struct packed {
    logic [7:0] ch;
    logic       plain;
    logic       mchar;
    logic       ctrl;
    logic       digit;
  } byte_cls_t;

  // one result
  typedef struct packed {
    logic [2:0]          status;
    logic [1:0]          method_code;
    logic                major;
    logic [9:0]          minor;
    logic                cpx;
    logic                quo;
    logic                plus;
    logic [POS_BITS-1:0] ub;
    logic [POS_BITS-1:0] uf;
    logic [POS_BITS-1:0] ab;
    logic [POS_BITS-1:0] eb;
  } result_t;
endpackage

// ===== rtl/core/hrlp_front.sv =====
// Front part: takes request bytes, classifies them, pushes into a two-entry queue.
// Depends on hrlp_pkg.
module hrlp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               q_valid,
  input  logic               q_pop,
  output hrlp_pkg::byte_cls_t q_data
);
  import hrlp_pkg::*;
  byte_cls_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  byte_cls_t  c;
  logic       push;

  always_comb begin
    c.ch = in_byte;
    c.plain = PLAIN_CHARS[in_byte];
    c.mchar = (in_byte inside {[8'h41:8'h5a]}) || in_byte == 8'h5f || in_byte == 8'h2d;
    c.ctrl = in_byte < 8'h20 || in_byte == 8'h7f;
    c.digit = in_byte inside {[8'h30:8'h39]};
  end

  assign in_stall = cnt == 2'd2;
  assign push = in_valid && !in_stall;
  assign q_valid = cnt != 2'd0;
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= c;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/core/hrlp_back.sv =====
// Back part: request-line state machine with an output register.
// Depends on hrlp_pkg.
module hrlp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  hrlp_pkg::byte_cls_t q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hrlp_pkg::result_t  res
);
  import hrlp_pkg::*;
  localparam logic [4:0] ST_START = 5'd0, ST_METHOD = 5'd1, ST_SP_URI = 5'd2,
    ST_SLASH = 5'd3, ST_CHECK = 5'd4, ST_URI = 5'd5, ST_H09 = 5'd6, ST_H = 5'd7,
    ST_HT = 5'd8, ST_HTT = 5'd9, ST_HTTP = 5'd10, ST_MAJ1 = 5'd11, ST_MAJ = 5'd12,
    ST_MIN1 = 5'd13, ST_MIN = 5'd14, ST_SP_END = 5'd15, ST_ALMOST = 5'd16;

  logic [4:0] state, state_next;
  logic [31:0] mbytes, mbytes_next;
  logic [2:0] mlen, mlen_next;
  logic major, major_next;
  logic [9:0] minor, minor_next;
  logic cpx, cpx_next, quo, quo_next, plus, plus_next;
  logic [POS_BITS-1:0] pos, pos_next, ub, ub_next, uf, uf_next, ab, ab_next;
  logic [POS_BITS-1:0] eb, eb_next, npos;
  logic [1:0] kind, kind_next;
  logic [2:0] rs;
  logic [7:0] ch;
  logic [3:0] dig;
  logic [13:0] m10;
  logic uend;

  assign ch = q_data.ch;
  assign dig = ch[3:0];
  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign npos = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
  assign m10 = {1'b0, minor, 3'b000} + {3'b000, minor, 1'b0} + {10'd0, dig};
  assign uend = ch == 8'h20 || ch == 8'h0d || ch == 8'h0a;

  function automatic logic [2:0] fin(input logic mj, input logic [9:0] mn,
                                     input logic [1:0] k);
    fin = (!mj && mn == 10'd9 && k != KIND_GET) ? RES_BAD_09 : RES_DONE;
  endfunction

  always_comb begin
    state_next = state; mbytes_next = mbytes; mlen_next = mlen;
    major_next = major; minor_next = minor; cpx_next = cpx; quo_next = quo;
    plus_next = plus; ub_next = ub; uf_next = uf; ab_next = ab; eb_next = eb;
    kind_next = kind; rs = RES_AGAIN;
    case (state)
      ST_START: begin
        if (ch == 8'h0d || ch == 8'h0a) begin
        end else if (!q_data.mchar) rs = RES_BAD_METHOD;
        else begin
          mbytes_next = {24'd0, ch}; mlen_next = 3'd1; major_next = 1'b0;
          minor_next = '0; cpx_next = 1'b0; quo_next = 1'b0; plus_next = 1'b0;
          ub_next = '0; uf_next = '0; ab_next = '0; eb_next = '0;
          kind_next = KIND_UNKNOWN; state_next = ST_METHOD;
        end
      end
      ST_METHOD: begin
        if (ch == 8'h20) begin
          if (mlen == 3'd3 && mbytes == 32'h00544547) kind_next = KIND_GET;
          else if (mlen == 3'd4 && mbytes == 32'h54534f50) kind_next = KIND_POST;
          else kind_next = KIND_UNKNOWN;
          state_next = ST_SP_URI;
        end else if (!q_data.mchar) rs = RES_BAD_METHOD;
        else begin
          case (mlen)
            3'd1: mbytes_next[15:8] = ch;
            3'd2: mbytes_next[23:16] = ch;
            3'd3: mbytes_next[31:24] = ch;
            default: begin end
          endcase
          if (mlen != 3'd7) mlen_next = mlen + 3'd1;
        end
      end
      ST_SP_URI: begin
        if (ch == 8'h2f) begin ub_next = pos; state_next = ST_SLASH; end
        else if (ch != 8'h20) rs = RES_BAD_REQ;
      end
      ST_SLASH, ST_CHECK, ST_URI: begin
        if (q_data.plain) begin
          if (state == ST_SLASH) state_next = ST_CHECK;
        end else if (uend) begin
          uf_next = pos;
          if (ch == 8'h20) state_next = ST_H09;
          else begin
            minor_next = 10'd9;
            if (ch == 8'h0d) state_next = ST_ALMOST;
            else rs = fin(major, 10'd9, kind);
          end
        end else if (state == ST_SLASH) begin
          if (ch == 8'h2e || ch == 8'h2f || ch == 8'h23) begin
            cpx_next = 1'b1; state_next = ST_URI;
          end else if (ch == 8'h25) begin quo_next = 1'b1; state_next = ST_URI; end
          else if (ch == 8'h3f) begin ab_next = npos; state_next = ST_URI; end
          else if (ch == 8'h2b) plus_next = 1'b1;
          else if (q_data.ctrl) rs = RES_BAD_REQ;
          else state_next = ST_CHECK;
        end else if (state == ST_CHECK) begin
          if (ch == 8'h2f) begin eb_next = '0; state_next = ST_SLASH; end
          else if (ch == 8'h2e) eb_next = npos;
          else if (ch == 8'h25) begin quo_next = 1'b1; state_next = ST_URI; end
          else if (ch == 8'h3f) begin ab_next = npos; state_next = ST_URI; end
          else if (ch == 8'h23) begin cpx_next = 1'b1; state_next = ST_URI; end
          else if (ch == 8'h2b) plus_next = 1'b1;
          else if (q_data.ctrl) rs = RES_BAD_REQ;
        end else begin
          if (ch == 8'h23) cpx_next = 1'b1;
          else if (q_data.ctrl) rs = RES_BAD_REQ;
        end
      end
      ST_H09: begin
        if (ch == 8'h20) begin
        end else if (ch == 8'h0d) begin minor_next = 10'd9; state_next = ST_ALMOST; end
        else if (ch == 8'h0a) begin minor_next = 10'd9; rs = fin(major, 10'd9, kind); end
        else if (ch == 8'h48) state_next = ST_H;
        else rs = RES_BAD_REQ;
      end
      ST_H: if (ch == 8'h54) state_next = ST_HT; else rs = RES_BAD_REQ;
      ST_HT: if (ch == 8'h54) state_next = ST_HTT; else rs = RES_BAD_REQ;
      ST_HTT: if (ch == 8'h50) state_next = ST_HTTP; else rs = RES_BAD_REQ;
      ST_HTTP: if (ch == 8'h2f) state_next = ST_MAJ1; else rs = RES_BAD_REQ;
      ST_MAJ1: begin
        if (!q_data.digit || ch == 8'h30) rs = RES_BAD_REQ;
        else if (ch != 8'h31) rs = RES_BAD_VER;
        else begin major_next = 1'b1; state_next = ST_MAJ; end
      end
      ST_MAJ: begin
        if (ch == 8'h2e) state_next = ST_MIN1;
        else if (!q_data.digit) rs = RES_BAD_REQ;
        else rs = RES_BAD_VER;
      end
      ST_MIN1: begin
        if (!q_data.digit) rs = RES_BAD_REQ;
        else begin minor_next = {6'd0, dig}; state_next = ST_MIN; end
      end
      ST_MIN: begin
        if (ch == 8'h0d) state_next = ST_ALMOST;
        else if (ch == 8'h0a) rs = fin(major, minor, kind);
        else if (ch == 8'h20) state_next = ST_SP_END;
        else if (!q_data.digit || minor > 10'd99) rs = RES_BAD_REQ;
        else minor_next = m10[9:0];
      end
      ST_SP_END: begin
        if (ch == 8'h20) begin
        end else if (ch == 8'h0d) state_next = ST_ALMOST;
        else if (ch == 8'h0a) rs = fin(major, minor, kind);
        else rs = RES_BAD_REQ;
      end
      ST_ALMOST: if (ch == 8'h0a) rs = fin(major, minor, kind); else rs = RES_BAD_REQ;
      default: state_next = ST_START;
    endcase
    if (rs != RES_AGAIN || (state == ST_ALMOST && ch == 8'h0a)) state_next = ST_START;
    if (state == ST_H09 && ch == 8'h0a) state_next = ST_START;
    pos_next = (state_next == ST_START) ? '0 : ((state == ST_START) ? 13'd1 : npos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START; mbytes <= '0; mlen <= '0; major <= 1'b0; minor <= '0;
      cpx <= 1'b0; quo <= 1'b0; plus <= 1'b0; pos <= '0; ub <= '0; uf <= '0;
      ab <= '0; eb <= '0; kind <= KIND_UNKNOWN; out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        state <= state_next; mbytes <= mbytes_next; mlen <= mlen_next;
        major <= major_next; minor <= minor_next; cpx <= cpx_next; quo <= quo_next;
        plus <= plus_next; pos <= pos_next; ub <= ub_next; uf <= uf_next;
        ab <= ab_next; eb <= eb_next; kind <= kind_next;
      end
      if (q_pop) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (q_pop) begin
      res.status <= rs; res.method_code <= kind_next; res.major <= major_next;
      res.minor <= minor_next; res.cpx <= cpx_next; res.quo <= quo_next;
      res.plus <= plus_next; res.ub <= ub_next; res.uf <= uf_next;
      res.ab <= ab_next; res.eb <= eb_next;
    end
  end
endmodule

// ===== rtl/core/http_request_line_parser.sv =====
// Top level of the HTTP request-line parser.
// Depends on hrlp_pkg, hrlp_front, hrlp_back.
//
// Usage:
//  - Input channel: in_valid/in_stall carry one raw request byte (in_byte)
//    per transfer; accepted when in_valid is high and in_stall low.
//  - Output channel: out_valid/out_stall carry exactly one result per byte:
//    status, method_code, version, URI flags and URI offsets.
//  - An accepted byte sits in the front queue until the state machine takes
//    it; its result is then held in the back's output register.
//  - Throughput: one byte per cycle while the output is not stalled, with one
//    state machine step per byte; the table lookup on the byte is in the front.
//  - A two-entry queue parts the front (classification) from the back
//    (state machine); the back holds its result register while out_valid and
//    out_stall are high, and the front keeps taking bytes until the queue is full.
//  - Reset (rst, synchronous): empties the queue, drops the output and
//    puts the parser in its start state with all offsets and flags zero.
//  - After done or any error the parser starts over with the next byte.
module http_request_line_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [1:0]                    method_code,
  output logic                          version_major,
  output logic [9:0]                    version_minor,
  output logic                          uri_complex,
  output logic                          uri_quoted,
  output logic                          uri_plus,
  output logic [hrlp_pkg::POS_BITS-1:0] uri_begin,
  output logic [hrlp_pkg::POS_BITS-1:0] uri_finish,
  output logic [hrlp_pkg::POS_BITS-1:0] args_begin,
  output logic [hrlp_pkg::POS_BITS-1:0] ext_begin
);
  import hrlp_pkg::*;
  logic q_valid, q_pop;
  byte_cls_t q_data;
  result_t res;

  hrlp_front u_front (.clk, .rst, .in_valid, .in_stall, .in_byte,
                      .q_valid, .q_pop, .q_data);
  hrlp_back u_back (.clk, .rst, .q_valid, .q_pop, .q_data,
                    .out_valid, .out_stall, .res);

  assign status = res.status;
  assign method_code = res.method_code;
  assign version_major = res.major;
  assign version_minor = res.minor;
  assign uri_complex = res.cpx;
  assign uri_quoted = res.quo;
  assign uri_plus = res.plus;
  assign uri_begin = res.ub;
  assign uri_finish = res.uf;
  assign args_begin = res.ab;
  assign ext_begin = res.eb;
endmodule

// ===== rtl/core/hrlp_checker.sv =====
// Port-level checks for the request-line parser, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module hrlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [1:0] method_code,
  input logic [9:0] version_minor
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "held result changed")
  `CHK_IMPL(a_status_range, clk, rst, out_valid, status <= 3'd5, "status out of range")
  `CHK_IMPL(a_kind_range, clk, rst, out_valid, method_code != 2'd3, "bad method code")
  `CHK_IMPL(a_minor_range, clk, rst, out_valid, version_minor <= 10'd999, "minor too big")
  `CHK_NEXT(a_in_to_out, clk, rst, in_valid && !in_stall && !out_valid, ##1 out_valid, "no result")
endmodule

bind http_request_line_parser hrlp_checker u_chk (.clk, .rst, .in_valid, .in_stall,
  .out_valid, .out_stall, .status, .method_code, .version_minor);

// ===== bench/tb_http_request_line_parser.sv =====
// Testbench for http_request_line_parser: drives request bytes, predicts each result.
// Depends on hrlp_pkg and the parser RTL; a directed table runs first, then random lines.
module tb_http_request_line_parser;
  import hrlp_pkg::*;

  typedef enum logic [4:0] {
    PS_START, PS_METHOD, PS_SP_URI, PS_SLASH, PS_CHECK, PS_URI, PS_H09, PS_H, PS_HT,
    PS_HTT, PS_HTTP, PS_MAJ1, PS_MAJ, PS_MIN1, PS_MIN, PS_SP_END, PS_ALMOST
  } pstate_t;

  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;
  localparam int LIMIT = 2000000;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic [7:0] in_byte;
  logic [2:0] status;
  logic [1:0] method_code;
  logic version_major;
  logic [9:0] version_minor;
  logic uri_complex, uri_quoted, uri_plus;
  logic [POS_BITS-1:0] uri_begin, uri_finish, args_begin, ext_begin;

  http_request_line_parser dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // predictor state
  pstate_t ps;
  logic [31:0] mbytes;
  logic [2:0] mlen;
  logic maj;
  logic [9:0] minv;
  logic fcpx, fquo, fplus;
  logic [POS_BITS-1:0] pos, ubeg, uend, apos, epos;
  logic [1:0] kind;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit sending_done = 0;

  function automatic bit plain_ch(logic [7:0] c);
    return PLAIN_CHARS[c];
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [POS_BITS-1:0] pos_next();
    return (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
  endfunction

  function automatic logic [2:0] line_done();
    return (maj == 1'b0 && minv == 10'd9 && kind != KIND_GET) ? RES_BAD_09 : RES_DONE;
  endfunction

  // URI terminators shared by the URI states; sets hit to 1 if c ended the URI
  task automatic uri_term(input logic [7:0] c, inout pstate_t ns, inout logic [2:0] r,
                          output bit hit);
    hit = 1;
    if (c == " ") begin
      uend = pos; ns = PS_H09;
    end else if (c == CR) begin
      uend = pos; minv = 10'd9; ns = PS_ALMOST;
    end else if (c == LF) begin
      uend = pos; minv = 10'd9; ns = PS_START; r = line_done();
    end else hit = 0;
  endtask

  function automatic bit ctrl_ch(logic [7:0] c);
    return c < 8'h20 || c == 8'h7f;
  endfunction

  function automatic bit mchar(logic [7:0] c);
    return (c >= "A" && c <= "Z") || c == "_" || c == "-";
  endfunction

  task automatic predict_byte(input logic [7:0] c, output result_t res);
    pstate_t ns;
    logic [2:0] r;
    bit hit;
    ns = ps;
    r = RES_AGAIN;
    case (ps)
      PS_START: begin
        pos = '0;
        if (c != CR && c != LF) begin
          if (!mchar(c)) r = RES_BAD_METHOD;
          else begin
            mbytes = {24'd0, c}; mlen = 3'd1; maj = 1'b0; minv = '0;
            {fcpx, fquo, fplus} = 3'b000;
            ubeg = '0; uend = '0; apos = '0; epos = '0; kind = KIND_UNKNOWN;
            ns = PS_METHOD;
          end
        end
      end
      PS_METHOD: begin
        if (c == " ") begin
          if (mlen == 3'd3 && mbytes == 32'h00544547) kind = KIND_GET;
          else if (mlen == 3'd4 && mbytes == 32'h54534f50) kind = KIND_POST;
          else kind = KIND_UNKNOWN;
          ns = PS_SP_URI;
        end else if (!mchar(c)) r = RES_BAD_METHOD;
        else begin
          if (mlen < 3'd4) mbytes[8*mlen +: 8] = c;
          if (mlen < 3'd7) mlen = mlen + 3'd1;
        end
      end
      PS_SP_URI: begin
        if (c == "/") begin ubeg = pos; ns = PS_SLASH; end
        else if (c != " ") r = RES_BAD_REQ;
      end
      PS_SLASH: begin
        if (plain_ch(c)) ns = PS_CHECK;
        else begin
          uri_term(c, ns, r, hit);
          if (!hit) begin
            if (c == "." || c == "/" || c == "#") begin fcpx = 1'b1; ns = PS_URI; end
            else if (c == "%") begin fquo = 1'b1; ns = PS_URI; end
            else if (c == "?") begin apos = pos_next(); ns = PS_URI; end
            else if (c == "+") fplus = 1'b1;
            else if (ctrl_ch(c)) r = RES_BAD_REQ;
            else ns = PS_CHECK;
          end
        end
      end
      PS_CHECK: begin
        if (!plain_ch(c)) begin
          uri_term(c, ns, r, hit);
          if (!hit) begin
            if (c == "/") begin epos = '0; ns = PS_SLASH; end
            else if (c == ".") epos = pos_next();
            else if (c == "%") begin fquo = 1'b1; ns = PS_URI; end
            else if (c == "?") begin apos = pos_next(); ns = PS_URI; end
            else if (c == "#") begin fcpx = 1'b1; ns = PS_URI; end
            else if (c == "+") fplus = 1'b1;
            else if (ctrl_ch(c)) r = RES_BAD_REQ;
          end
        end
      end
      PS_URI: begin
        if (!plain_ch(c)) begin
          uri_term(c, ns, r, hit);
          if (!hit) begin
            if (c == "#") fcpx = 1'b1;
            else if (ctrl_ch(c)) r = RES_BAD_REQ;
          end
        end
      end
      PS_H09: begin
        if (c == CR) begin minv = 10'd9; ns = PS_ALMOST; end
        else if (c == LF) begin minv = 10'd9; ns = PS_START; r = line_done(); end
        else if (c == "H") ns = PS_H;
        else if (c != " ") r = RES_BAD_REQ;
      end
      PS_H: if (c == "T") ns = PS_HT; else r = RES_BAD_REQ;
      PS_HT: if (c == "T") ns = PS_HTT; else r = RES_BAD_REQ;
      PS_HTT: if (c == "P") ns = PS_HTTP; else r = RES_BAD_REQ;
      PS_HTTP: if (c == "/") ns = PS_MAJ1; else r = RES_BAD_REQ;
      PS_MAJ1: begin
        if (c < "1" || c > "9") r = RES_BAD_REQ;
        else if (c > "1") r = RES_BAD_VER;
        else begin maj = 1'b1; ns = PS_MAJ; end
      end
      PS_MAJ: begin
        if (c == ".") ns = PS_MIN1;
        else if (!is_digit(c)) r = RES_BAD_REQ;
        else r = RES_BAD_VER;
      end
      PS_MIN1: begin
        if (!is_digit(c)) r = RES_BAD_REQ;
        else begin minv = {2'b00, 8'(c - 8'h30)}; ns = PS_MIN; end
      end
      PS_MIN: begin
        if (c == CR) ns = PS_ALMOST;
        else if (c == LF) begin ns = PS_START; r = line_done(); end
        else if (c == " ") ns = PS_SP_END;
        else if (!is_digit(c) || minv > 10'd99) r = RES_BAD_REQ;
        else minv = 10'(minv * 10'd10 + {2'b00, 8'(c - 8'h30)});
      end
      PS_SP_END: begin
        if (c == CR) ns = PS_ALMOST;
        else if (c == LF) begin ns = PS_START; r = line_done(); end
        else if (c != " ") r = RES_BAD_REQ;
      end
      PS_ALMOST: begin
        if (c == LF) begin ns = PS_START; r = line_done(); end
        else r = RES_BAD_REQ;
      end
      default: ns = PS_START;
    endcase
    if (r != RES_AGAIN) ns = PS_START;
    res = '{status: r, method_code: kind, major: maj, minor: minv, cpx: fcpx, quo: fquo,
            plus: fplus, ub: ubeg, uf: uend, ab: apos, eb: epos};
    ps = ns;
    pos = (ns == PS_START) ? '0 : pos_next();
  endtask

  // Directed rows: byte plus, where obvious, the status it must give (-1 = predictor only).
  typedef struct {
    logic [7:0] b;
    int st;
  } drow_t;

  drow_t directed[] = '{
    '{8'h00, RES_BAD_METHOD}, '{8'hff, RES_BAD_METHOD}, '{CR, RES_AGAIN}, '{LF, RES_AGAIN},
    '{"G", -1}, '{"E", -1}, '{"T", -1}, '{" ", -1}, '{"/", -1}, '{"a", -1}, '{".", -1},
    '{"h", -1}, '{"?", -1}, '{"+", -1}, '{" ", -1}, '{"H", -1}, '{"T", -1}, '{"T", -1},
    '{"P", -1}, '{"/", -1}, '{"2", RES_BAD_VER}, '{"P", -1}, '{" ", -1}, '{"/", -1},
    '{LF, RES_BAD_09}
  };

  // request stream; producer and checker are separate processes
  logic [7:0] bytes_q[$];

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) bytes_q.push_back(s[i]);
  endtask

  function automatic string rand_uri_char();
    string pool = "abcxyz019./%?#+-_~ /";
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return string'(8'($urandom_range(0, 255)));
    return string'(pool[$urandom_range(0, pool.len() - 1)]);
  endfunction

  // builds one random request line, mostly well formed
  task automatic push_line();
    string s, meth[] = '{"GET", "POST", "PUT", "GE", "POSTX", "A_B-CDEFGH", "GEX"};
    int n;
    s = "";
    if ($urandom_range(0, 9) == 0) s = {s, "\r\n"};
    s = {s, meth[$urandom_range(0, meth.size() - 1)], " "};
    if ($urandom_range(0, 3) == 0) s = {s, " "};
    s = {s, "/"};
    n = $urandom_range(0, 14);
    for (int i = 0; i < n; i++) s = {s, rand_uri_char()};
    case ($urandom_range(0, 9))
      0: s = {s, "\n"};
      1: s = {s, "\r\n"};
      2: s = {s, " \r\n"};
      3: s = {s, " HTTP/1.", string'(8'("0" + $urandom_range(0, 9))), "\r\n"};
      4: s = {s, " HTTP/1.", $sformatf("%0d", $urandom_range(0, 9999)), "  \n"};
      5: s = {s, " HTTP/", string'(8'("0" + $urandom_range(0, 9))), ".1\r\n"};
      6: s = {s, " HTTP/11.1\n"};
      7: s = {s, " HTXP/1.1\r\n"};
      default: s = {s, " HTTP/1.1\r\n"};
    endcase
    // occasional corruption
    if ($urandom_range(0, 9) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
    push_str(s);
  endtask

  int sent = 0;
  int dir_status[$];

  // sender
  initial begin
    int gap;
    logic [7:0] b;
    rst = 1; in_valid = 0; in_byte = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      bytes_q.push_back(directed[i].b);
      dir_status.push_back(directed[i].st);
    end
    while (bytes_q.size() < 1400) push_line();
    while (bytes_q.size() > 0) begin
      b = bytes_q.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1;
      in_byte <= b;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      begin
        result_t r;
        predict_byte(b, r);
        pending_results.push_back(r);
      end
      sent++;
    end
    in_valid <= 0;
    sending_done = 1;
  end

  // receiver: per-result stall draw, checks each result against the oldest prediction
  initial begin
    result_t e;
    int st;
    int hold;
    out_stall = 0;
    hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = pending_results.pop_front();
          st = (dir_status.size() > 0) ? dir_status.pop_front() : -1;
          if (st >= 0 && status != 3'(st)) begin
            $error("status table exp %0d got %0d", st, status); errors++;
          end
          if (status != e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++; end
          if (method_code != e.method_code) begin
            $error("method_code exp %0d got %0d", e.method_code, method_code); errors++; end
          if (version_major != e.major) begin
            $error("version_major exp %0d got %0d", e.major, version_major); errors++; end
          if (version_minor != e.minor) begin
            $error("version_minor exp %0d got %0d", e.minor, version_minor); errors++; end
          if (uri_complex != e.cpx) begin
            $error("uri_complex exp %0d got %0d", e.cpx, uri_complex); errors++; end
          if (uri_quoted != e.quo) begin
            $error("uri_quoted exp %0d got %0d", e.quo, uri_quoted); errors++; end
          if (uri_plus != e.plus) begin
            $error("uri_plus exp %0d got %0d", e.plus, uri_plus); errors++; end
          if (uri_begin != e.ub) begin
            $error("uri_begin exp %0d got %0d", e.ub, uri_begin); errors++; end
          if (uri_finish != e.uf) begin
            $error("uri_finish exp %0d got %0d", e.uf, uri_finish); errors++; end
          if (args_begin != e.ab) begin
            $error("args_begin exp %0d got %0d", e.ab, args_begin); errors++; end
          if (ext_begin != e.eb) begin
            $error("ext_begin exp %0d got %0d", e.eb, ext_begin); errors++; end
        end
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1;
        hold--;
      end else out_stall <= 0;
    end
  end

  // end of run and watchdog
  initial begin
    ps = PS_START; mbytes = '0; mlen = '0; maj = 1'b0; minv = '0;
    {fcpx, fquo, fplus} = 3'b000; pos = '0; ubeg = '0; uend = '0; apos = '0; epos = '0;
    kind = KIND_UNKNOWN;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (sending_done && pending_results.size() == 0) begin
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
      end
    end
  end
endmodule
